[hw/rtl/earp_pkg.sv]
// Shared constants and helpers for the roll-pitch-yaw point rotator.
// No dependencies; used by the CORDIC stage, the matrix stage and the top level.
`default_nettype none
package earp_pkg;
	localparam int CordicStepsDefault = 16;
	localparam int CoordBitsDefault   = 24;
	localparam int AtanLen            = 24;
	localparam int AngW               = 16;
	localparam int ZW                 = 20;
	localparam int TW                 = 17;
	localparam int MW                 = 17;

	localparam logic signed [ZW-1:0] HalfPi   = 20'sd102944;
	localparam logic signed [ZW-1:0] Pi       = 20'sd205887;
	localparam logic signed [TW-1:0] CordGain = 17'sd9949;
	localparam logic signed [TW-1:0] OneQ14   = 17'sd16384;

	// Arctangent of 2^-i in units of 2^-16 rad.
	function automatic logic signed [ZW-1:0] atan_lut(input int i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				0: r = 20'sd51472;
				1: r = 20'sd30386;
				2: r = 20'sd16055;
				3: r = 20'sd8150;
				4: r = 20'sd4091;
				5: r = 20'sd2047;
				6: r = 20'sd1024;
				7: r = 20'sd512;
				8: r = 20'sd256;
				9: r = 20'sd128;
				10: r = 20'sd64;
				11: r = 20'sd32;
				12: r = 20'sd16;
				13: r = 20'sd8;
				14: r = 20'sd4;
				15: r = 20'sd2;
				16: r = 20'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// Product of two Q1.14 values, rounded half up.
	function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
			input logic signed [MW-1:0] b);
		logic signed [2*MW-1:0] p;
		begin
			p = a * b + 34'sd8192;
			return p[MW+13:14];
		end
	endfunction
endpackage
`default_nettype wire

[hw/rtl/earp_cordic.sv]
// Pipelined rotation-mode CORDIC: sine and cosine of one angle in Q1.14.
// Depends on earp_pkg. One iteration per register stage, stall freezes all stages.
`default_nettype none
module earp_cordic import earp_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDefault
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [AngW-1:0] angle,
	output logic signed [TW-1:0]       sin_o,
	output logic signed [TW-1:0]       cos_o
);
	localparam int N = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;

	logic signed [TW-1:0] x_q [N+1];
	logic signed [TW-1:0] y_q [N+1];
	logic signed [ZW-1:0] z_q [N+1];
	logic                 n_q [N+1];
	logic signed [ZW-1:0] z0;
	logic signed [TW-1:0] xc, yc;

	// Fold the angle into the right half plane.
	always_comb begin
		z0 = ZW'(angle) <<< 3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= CordGain;
			y_q[0] <= '0;
			if (z0 > HalfPi) begin
				z_q[0] <= z0 - Pi;
				n_q[0] <= 1'b1;
			end else if (z0 < -HalfPi) begin
				z_q[0] <= z0 + Pi;
				n_q[0] <= 1'b1;
			end else begin
				z_q[0] <= z0;
				n_q[0] <= 1'b0;
			end
		end
	end

	// One micro-rotation per stage.
	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i+1] <= n_q[i];
				if (z_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_lut(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_lut(i);
				end
			end
		end
	end

	// Clamp to unit range and restore the sign.
	always_comb begin
		xc = (x_q[N] > OneQ14) ? OneQ14 : ((x_q[N] < -OneQ14) ? -OneQ14 : x_q[N]);
		yc = (y_q[N] > OneQ14) ? OneQ14 : ((y_q[N] < -OneQ14) ? -OneQ14 : y_q[N]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= n_q[N] ? -xc : xc;
			sin_o <= n_q[N] ? -yc : yc;
		end
	end

	// The z residual of the last stage is not needed further.
	logic unused_z;
	assign unused_z = ^z_q[N];
endmodule
`default_nettype wire

[hw/rtl/earp_xform.sv]
// Matrix build and point transform stages after the CORDIC units.
// Depends on earp_pkg. Four register stages; the first three each hold one layer of multiplies.
`default_nettype none
module earp_xform import earp_pkg::*; #(
	parameter int COORD_BITS = CoordBitsDefault
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic signed [TW-1:0]         sr, cr, sp, cp, sy, cy,
	input  wire logic signed [COORD_BITS-1:0] px, py, pz,
	output logic signed [COORD_BITS-1:0]      rx, ry, rz,
	output logic                              clip
);
	localparam int AW = COORD_BITS + MW + 3;
	localparam logic signed [AW-1:0] SatHi = AW'((longint'(1) <<< (COORD_BITS - 1)) - 1);
	localparam logic signed [AW-1:0] SatLo = -SatHi - AW'(1);

	logic signed [MW-1:0] srsp_s1, crsp_s1, m0_s1, m1_s1, m2_s1, m5_s1, m8_s1;
	logic signed [MW-1:0] crsy_s1, crcy_s1, srsy_s1, srcy_s1, sy_s1, cy_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, pz_s1, px_s2, py_s2, pz_s2;
	logic signed [MW-1:0] m_s2 [9];
	logic signed [AW-1:0] pr_s3 [9];
	logic signed [AW-1:0] acc [3];
	logic signed [COORD_BITS-1:0] res [3];
	logic [2:0] ovf;

	// Stage 1: pairwise products.
	always_ff @(posedge clk) begin
		if (en) begin
			srsp_s1 <= mulq(sr, sp);
			crsp_s1 <= mulq(cr, sp);
			m0_s1 <= mulq(cp, cy);
			m1_s1 <= mulq(cp, sy);
			m2_s1 <= -sp;
			m5_s1 <= mulq(sr, cp);
			m8_s1 <= mulq(cr, cp);
			crsy_s1 <= mulq(cr, sy);
			crcy_s1 <= mulq(cr, cy);
			srsy_s1 <= mulq(sr, sy);
			srcy_s1 <= mulq(sr, cy);
			sy_s1 <= sy;
			cy_s1 <= cy;
			px_s1 <= px; py_s1 <= py; pz_s1 <= pz;
		end
	end

	// Stage 2: triple products and the finished matrix.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s2[0] <= m0_s1;
			m_s2[1] <= m1_s1;
			m_s2[2] <= m2_s1;
			m_s2[3] <= -crsy_s1 + mulq(srsp_s1, cy_s1);
			m_s2[4] <= crcy_s1 + mulq(srsp_s1, sy_s1);
			m_s2[5] <= m5_s1;
			m_s2[6] <= srsy_s1 + mulq(crsp_s1, cy_s1);
			m_s2[7] <= -srcy_s1 + mulq(crsp_s1, sy_s1);
			m_s2[8] <= m8_s1;
			px_s2 <= px_s1; py_s2 <= py_s1; pz_s2 <= pz_s1;
		end
	end

	// Stage 3: matrix times point, operands widened so the full product is kept.
	for (genvar r = 0; r < 3; r++) begin : g_row
		always_ff @(posedge clk) begin
			if (en) begin
				pr_s3[3*r]   <= AW'(m_s2[3*r]) * AW'(px_s2);
				pr_s3[3*r+1] <= AW'(m_s2[3*r+1]) * AW'(py_s2);
				pr_s3[3*r+2] <= AW'(m_s2[3*r+2]) * AW'(pz_s2);
			end
		end

		// Stage 4: sum, round and saturate.
		always_comb begin
			logic signed [AW-1:0] v;
			v = (pr_s3[3*r] + pr_s3[3*r+1] + pr_s3[3*r+2] + AW'(8192)) >>> 14;
			acc[r] = v;
			if (v > SatHi) begin
				res[r] = {1'b0, {(COORD_BITS-1){1'b1}}};
				ovf[r] = 1'b1;
			end else if (v < SatLo) begin
				res[r] = {1'b1, {(COORD_BITS-1){1'b0}}};
				ovf[r] = 1'b1;
			end else begin
				res[r] = v[COORD_BITS-1:0];
				ovf[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx <= res[0];
			ry <= res[1];
			rz <= res[2];
			clip <= |ovf;
		end
	end

	logic unused_acc;
	assign unused_acc = ^{acc[0], acc[1], acc[2]};
endmodule
`default_nettype wire

[hw/rtl/euler_axes_rotate_point.sv]
// Roll-pitch-yaw axes rotation of a 3D point.
// Input channel: in_valid/in_stall with three Q2.13 angles and a point.
// Output channel: out_valid/out_stall with the rotated, rounded and
// saturated point and a clipped flag.
// Each angle goes through its own pipelined CORDIC, one iteration per
// stage, then the matrix is built in two stages and applied in two more.
// One beat is accepted every cycle while the output is not stalled.
// The CORDIC chain depth sets the latency.
// The whole pipe advances together: while out_stall is high and the last
// stage holds a beat, every stage holds, and in_stall goes high at once.
// Empty stages hold as well while the output is stalled; bubbles are not
// squeezed out.
// Reset clears the valid bits of all stages; data registers are not reset.
// Depends on earp_pkg, earp_cordic and earp_xform.
`default_nettype none
module euler_axes_rotate_point import earp_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDefault,
	parameter int COORD_BITS   = CoordBitsDefault
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [AngW-1:0]       roll_angle,
	input  wire logic signed [AngW-1:0]       pitch_angle,
	input  wire logic signed [AngW-1:0]       yaw_angle,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic signed [COORD_BITS-1:0] pos_y,
	input  wire logic signed [COORD_BITS-1:0] pos_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [COORD_BITS-1:0]      rot_x,
	output logic signed [COORD_BITS-1:0]      rot_y,
	output logic signed [COORD_BITS-1:0]      rot_z,
	output logic                              clipped
);
	localparam int N    = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
	localparam int CLAT = N + 2;
	localparam int LAT  = CLAT + 4;

	logic en;
	logic [LAT-1:0] vld_q;
	logic signed [COORD_BITS-1:0] px_q [CLAT];
	logic signed [COORD_BITS-1:0] py_q [CLAT];
	logic signed [COORD_BITS-1:0] pz_q [CLAT];
	logic signed [TW-1:0] sr, cr, sp, cp, sy, cy;

	// Global advance: hold only when a finished beat is blocked.
	assign en        = !(vld_q[LAT-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Point delay line matching the CORDIC latency.
	always_ff @(posedge clk) begin
		if (en) begin
			px_q[0] <= pos_x;
			py_q[0] <= pos_y;
			pz_q[0] <= pos_z;
			for (int k = 1; k < CLAT; k++) begin
				px_q[k] <= px_q[k-1];
				py_q[k] <= py_q[k-1];
				pz_q[k] <= pz_q[k-1];
			end
		end
	end

	earp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
		.clk, .en, .angle(roll_angle), .sin_o(sr), .cos_o(cr));
	earp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
		.clk, .en, .angle(pitch_angle), .sin_o(sp), .cos_o(cp));
	earp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
		.clk, .en, .angle(yaw_angle), .sin_o(sy), .cos_o(cy));

	earp_xform #(.COORD_BITS(COORD_BITS)) u_xform (
		.clk, .en, .sr, .cr, .sp, .cp, .sy, .cy,
		.px(px_q[CLAT-1]), .py(py_q[CLAT-1]), .pz(pz_q[CLAT-1]),
		.rx(rot_x), .ry(rot_y), .rz(rot_z), .clip(clipped));
endmodule
`default_nettype wire
